// ===== hw/rtl/sprite_rle_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// sprite_rle_decoder_macros: assertion macros for the sprite decoder checks
// ----------------------------------------------------------------------------
`ifndef SPRITE_RLE_DECODER_MACROS_SVH
`define SPRITE_RLE_DECODER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SRD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sprite_rle_decoder check failed");

// next-cycle implication, disabled while reset is low
`define SRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sprite_rle_decoder check failed");

`endif

// ===== hw/rtl/srd_pkg.sv =====
// ----------------------------------------------------------------------------
// srd_pkg
// Types and constants shared by the sprite run-length decoder and its checker.
// ----------------------------------------------------------------------------
package srd_pkg;

    localparam int SPRITE_SIDE_DEF = 32;
    localparam int PIX_IDX_W       = 10;
    localparam int CONSUMED_W      = 17;

    typedef enum logic [3:0] {
        PH_SIZE_LO = 4'd0,
        PH_SIZE_HI = 4'd1,
        PH_SKIP_LO = 4'd2,
        PH_SKIP_HI = 4'd3,
        PH_CNT_LO  = 4'd4,
        PH_CNT_HI  = 4'd5,
        PH_RED     = 4'd6,
        PH_GREEN   = 4'd7,
        PH_BLUE    = 4'd8,
        PH_ALPHA   = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       sprite_start;
    } in_beat_t;

    typedef struct packed {
        kind_t                  kind;
        logic [PIX_IDX_W-1:0]   pixel_index;
        logic [7:0]             red;
        logic [7:0]             green;
        logic [7:0]             blue;
        logic [7:0]             alpha;
        logic                   sprite_last;
    } out_beat_t;

endpackage

// ===== hw/rtl/sprite_rle_decoder.sv =====
// ----------------------------------------------------------------------------
// sprite_rle_decoder
// Decodes one transparent run-length sprite stream into pixel write beats.
// ----------------------------------------------------------------------------
// One encoded byte enters per beat and the decoder takes a new byte every
// cycle: the parser state advances in the cycle the byte is accepted and any
// result lands in a single output register, so s_ready stays high as long as
// that register is empty or being drained (s_ready = !m_valid || m_ready).
// Sustained rate is one byte per cycle; a result appears on m_data in the cycle
// after the alpha byte (or the byte that ends the sprite) is accepted. Each
// sprite opens with a little-endian 16-bit size, then groups of skip count,
// colored count and RGBA quadruples. Every alpha byte yields a pixel write at
// its raster index (row = index / SPRITE_SIDE); transparent pixels are only
// skipped, so the consumer must clear the sprite first. The last beat of a
// sprite has sprite_last set; an end without pixel or an index past the
// sprite area gives a marker beat, after which bytes are dropped until a beat
// with sprite_start. Parsing starts right after reset without a start mark.
// ----------------------------------------------------------------------------
module sprite_rle_decoder #(
    parameter int SPRITE_SIDE = srd_pkg::SPRITE_SIDE_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  srd_pkg::in_beat_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output srd_pkg::out_beat_t m_data
);

    // sprite area and the widths that follow from it
    localparam int AREA  = SPRITE_SIDE * SPRITE_SIDE;
    localparam int POS_W = $clog2(AREA + 1);
    localparam int SUM_W = ((POS_W > 16) ? POS_W : 16) + 1;
    localparam int CNT_W = srd_pkg::CONSUMED_W;

    localparam logic [POS_W-1:0] AREA_P = POS_W'(AREA);
    localparam logic [SUM_W-1:0] AREA_S = SUM_W'(AREA);

    // parser state
    srd_pkg::phase_t    phase_reg, phase_next;
    logic               halted_reg, halted_next;
    logic [15:0]        size_reg, size_next;
    logic [CNT_W-1:0]   consumed_reg, consumed_next;
    logic [POS_W-1:0]   position_reg, position_next;
    logic [SUM_W-1:0]   run_end_reg, run_end_next;
    logic [7:0]         low_reg, low_next;
    logic [7:0]         red_reg, red_next;
    logic [7:0]         green_reg, green_next;
    logic [7:0]         blue_reg, blue_next;

    // result register
    logic               m_valid_reg;
    srd_pkg::out_beat_t m_data_reg;
    srd_pkg::out_beat_t result;
    logic               emit;

    // helpers
    srd_pkg::phase_t    phase_eff;
    logic               halted_eff;
    logic [15:0]        word;
    logic [SUM_W-1:0]   pos_plus_word;
    logic [CNT_W:0]     consumed_add;
    logic [CNT_W-1:0]   consumed_sat;
    logic               consumed_done;
    logic [POS_W-1:0]   position_inc;
    logic [31:0]        position_ext;
    logic               s_fire;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a start mark restarts the parser on this very byte
    assign phase_eff  = s_data.sprite_start ? srd_pkg::PH_SIZE_LO : phase_reg;
    assign halted_eff = s_data.sprite_start ? 1'b0 : halted_reg;

    assign word          = {s_data.data_byte, low_reg};
    assign pos_plus_word = SUM_W'(position_reg) + SUM_W'(word);

    // consumed count saturates; any value at or past 64k compares the same
    assign consumed_add  = {1'b0, consumed_reg} + (CNT_W + 1)'(4);
    assign consumed_sat  = consumed_add[CNT_W] ? '1 : consumed_add[CNT_W-1:0];
    assign consumed_done = consumed_sat >= CNT_W'(size_reg);

    assign position_inc = position_reg + POS_W'(1);
    assign position_ext = 32'(position_reg);

    always_comb begin
        phase_next    = phase_eff;
        halted_next   = halted_eff;
        size_next     = size_reg;
        consumed_next = consumed_reg;
        position_next = position_reg;
        run_end_next  = run_end_reg;
        low_next      = low_reg;
        red_next      = red_reg;
        green_next    = green_reg;
        blue_next     = blue_reg;
        emit          = 1'b0;
        result        = '0;
        result.kind   = srd_pkg::KIND_PIXEL;

        if (!halted_eff) begin
            unique case (phase_eff) inside
                srd_pkg::PH_SIZE_LO, srd_pkg::PH_SKIP_LO, srd_pkg::PH_CNT_LO: begin
                    low_next   = s_data.data_byte;
                    phase_next = srd_pkg::phase_t'(phase_eff + 4'd1);
                end
                srd_pkg::PH_SIZE_HI: begin
                    size_next     = word;
                    consumed_next = '0;
                    position_next = '0;
                    if (word == 16'd0) begin
                        // empty sprite: end marker
                        emit               = 1'b1;
                        result.kind        = srd_pkg::KIND_END;
                        result.sprite_last = 1'b1;
                        halted_next        = 1'b1;
                        phase_next         = srd_pkg::PH_SIZE_LO;
                    end else begin
                        phase_next = srd_pkg::PH_SKIP_LO;
                    end
                end
                srd_pkg::PH_SKIP_HI: begin
                    // skip saturates at the sprite area
                    position_next = (pos_plus_word > AREA_S) ? AREA_P
                                                             : pos_plus_word[POS_W-1:0];
                    phase_next    = srd_pkg::PH_CNT_LO;
                end
                srd_pkg::PH_CNT_HI: begin
                    consumed_next = consumed_sat;
                    run_end_next  = pos_plus_word;
                    if (word == 16'd0) begin
                        if (consumed_done) begin
                            emit               = 1'b1;
                            result.kind        = srd_pkg::KIND_END;
                            result.sprite_last = 1'b1;
                            halted_next        = 1'b1;
                            phase_next         = srd_pkg::PH_SIZE_LO;
                        end else begin
                            phase_next = srd_pkg::PH_SKIP_LO;
                        end
                    end else begin
                        phase_next = srd_pkg::PH_RED;
                    end
                end
                srd_pkg::PH_RED: begin
                    red_next   = s_data.data_byte;
                    phase_next = srd_pkg::PH_GREEN;
                end
                srd_pkg::PH_GREEN: begin
                    green_next = s_data.data_byte;
                    phase_next = srd_pkg::PH_BLUE;
                end
                srd_pkg::PH_BLUE: begin
                    blue_next  = s_data.data_byte;
                    phase_next = srd_pkg::PH_ALPHA;
                end
                srd_pkg::PH_ALPHA: begin
                    emit = 1'b1;
                    if (position_reg >= AREA_P) begin
                        // write past the sprite area
                        result.kind        = srd_pkg::KIND_ERROR;
                        result.sprite_last = 1'b1;
                        halted_next        = 1'b1;
                        phase_next         = srd_pkg::PH_SIZE_LO;
                    end else begin
                        result.pixel_index = position_ext[srd_pkg::PIX_IDX_W-1:0];
                        result.red         = red_reg;
                        result.green       = green_reg;
                        result.blue        = blue_reg;
                        result.alpha       = s_data.data_byte;
                        position_next      = position_inc;
                        consumed_next      = consumed_sat;
                        if (SUM_W'(position_inc) >= run_end_reg) begin
                            if (consumed_done) begin
                                result.sprite_last = 1'b1;
                                halted_next        = 1'b1;
                                phase_next         = srd_pkg::PH_SIZE_LO;
                            end else begin
                                phase_next = srd_pkg::PH_SKIP_LO;
                            end
                        end else begin
                            phase_next = srd_pkg::PH_RED;
                        end
                    end
                end
                default: begin
                    phase_next = srd_pkg::PH_SIZE_LO;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= srd_pkg::PH_SIZE_LO;
            halted_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                phase_reg  <= phase_next;
                halted_reg <= halted_next;
            end
            if (s_fire && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers, each written before it is read
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            size_reg     <= size_next;
            consumed_reg <= consumed_next;
            position_reg <= position_next;
            run_end_reg  <= run_end_next;
            low_reg      <= low_next;
            red_reg      <= red_next;
            green_reg    <= green_next;
            blue_reg     <= blue_next;
        end
        if (s_fire && emit) begin
            m_data_reg <= result;
        end
    end

endmodule

// ===== hw/rtl/srd_checker.sv =====
// ----------------------------------------------------------------------------
// srd_checker
// Port-level checks for the sprite run-length decoder, bound to its top level.
// ----------------------------------------------------------------------------
`include "sprite_rle_decoder_macros.svh"

module srd_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input srd_pkg::out_beat_t m_data
);

    logic marker_beat;
    logic marker_clean;
    logic kind_known;

    assign marker_beat  = m_valid && (m_data.kind != srd_pkg::KIND_PIXEL);
    assign marker_clean = m_data.sprite_last && (m_data.pixel_index == '0) &&
                          (m_data.red == 8'd0) && (m_data.green == 8'd0) &&
                          (m_data.blue == 8'd0) && (m_data.alpha == 8'd0);
    assign kind_known   = (m_data.kind == srd_pkg::KIND_PIXEL) ||
                          (m_data.kind == srd_pkg::KIND_END) ||
                          (m_data.kind == srd_pkg::KIND_ERROR);

    // a stalled result beat holds
    `SRD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    // end and error beats close the sprite and carry no pixel
    `SRD_ASSERT_IMPL(a_marker_clean, aclk, aresetn, marker_beat, marker_clean)
    // only the three defined kinds appear
    `SRD_ASSERT_IMPL(a_kind_valid, aclk, aresetn, m_valid, kind_known)
    // an empty result register never blocks the input
    `SRD_ASSERT_IMPL(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)

endmodule

bind sprite_rle_decoder srd_checker u_srd_checker (.*);
